// ----- rtl/bmap_pkg.sv -----
// Shared constants, codes and types of the allocation bitmap block.
package bmap_pkg;

   localparam int MAP_BYTES_DEF = 32;  // default number of bitmap rows
   localparam int ADDR_ROWS     = 32;  // rows an 8-bit bit number can reach
   localparam int ROW_BITS      = 8;
   localparam int ROW_SHIFT     = 3;
   localparam int CSR_W         = 6;
   localparam int REQ_TDATA_W   = 16;
   localparam int RSP_TDATA_W   = 16;

   localparam logic [CSR_W-1:0] CSR_RESET = 6'd32;

   // command codes; the unused code behaves as test
   localparam logic [1:0] CMD_SET   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_TEST  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MODIFY,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;      // latch the accepted item
      logic read_row;     // read the addressed row
      logic update;       // modify and write back the row, reset the scan
      logic scan_run;     // advance the first-free scan
      logic load_result;  // move the result into the output register
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;    // first-free search finished
      logic rsp_busy;     // output register holds an item that is not taken
   } sts_type;

endpackage

// ----- rtl/bmap_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bmap_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 32,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/bmap_ctrl.sv -----
// Controller state machine of the allocation bitmap block.
module bmap_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  bmap_pkg::sts_type sts,
   output bmap_pkg::ctl_type ctl
);
   import bmap_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            ctl.read_row = 1'b1;
            state_in     = ST_MODIFY;
         end
         ST_MODIFY: begin
            ctl.update = 1'b1;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            ctl.scan_run = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!sts.rsp_busy) begin
               ctl.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/bmap_dp.sv -----
// Datapath of the allocation bitmap block: map rows, update, scan, result.
module bmap_dp #(
   parameter int MAP_BYTES = bmap_pkg::MAP_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bmap_pkg::ctl_type           ctl,
   output bmap_pkg::sts_type           sts,
   input  logic [1:0]                  req_command,
   input  logic [7:0]                  req_bit_index,
   input  logic                        csr_we,
   input  logic [bmap_pkg::CSR_W-1:0]  csr_wdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic                        rsp_bit_value,
   output logic [7:0]                  rsp_first_free_index,
   output logic                        rsp_none_free,
   output logic                        rsp_out_of_range
);
   import bmap_pkg::*;

   localparam int ROWS = (MAP_BYTES < ADDR_ROWS) ? MAP_BYTES : ADDR_ROWS;
   localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW   = $clog2(ROWS + 1);

   function automatic logic [2:0] low_zero(input logic [ROW_BITS-1:0] v);
      logic [2:0] pos;
      pos = '0;
      for (int i = ROW_BITS - 1; i >= 0; i--) begin
         if (!v[i]) pos = 3'(i);
      end
      return pos;
   endfunction

   // configuration
   logic [CSR_W-1:0] csr_ff;
   logic [CSR_W-1:0] rows_lim;

   // item
   logic [1:0]  cmd_ff;
   logic [7:0]  bit_ff;
   logic        oor_ff;
   logic        bit_value_ff;
   logic [4:0]  tgt_row;

   // row storage
   logic [ROWS-1:0]     row_valid_ff, row_valid_in;
   logic                rd_valid_ff;
   logic [AW-1:0]       rd_addr;
   logic [ROW_BITS-1:0] rd_data, byte_val, new_byte, mask;
   logic                wr_en;

   // scan
   logic [CW-1:0] scan_issue_ff;
   logic          issue_ok, issue;
   logic          check_vld_ff;
   logic [4:0]    check_row_ff;
   logic          found_ff;
   logic [7:0]    first_ff;

   // output register
   logic       rsp_tvalid_ff;
   logic       rsp_bit_value_ff, rsp_none_free_ff, rsp_out_of_range_ff;
   logic [7:0] rsp_first_ff;

   assign rows_lim = (csr_ff > CSR_W'(ROWS)) ? CSR_W'(ROWS) : csr_ff;
   assign tgt_row  = 5'(bit_ff >> ROW_SHIFT);
   assign issue_ok = CSR_W'(scan_issue_ff) < rows_lim;
   assign issue    = ctl.scan_run && issue_ok && !found_ff;
   assign byte_val = rd_valid_ff ? rd_data : '0;
   assign mask     = ROW_BITS'(1) << bit_ff[2:0];
   assign wr_en    = ctl.update && !oor_ff;

   always_comb begin
      if (ctl.read_row && !oor_ff) begin
         rd_addr = tgt_row[AW-1:0];
      end else if (issue_ok) begin
         rd_addr = scan_issue_ff[AW-1:0];
      end else begin
         rd_addr = '0;
      end
   end

   always_comb begin
      case (cmd_ff)
         CMD_SET:   new_byte = byte_val | mask;
         CMD_CLEAR: new_byte = byte_val & ~mask;
         default:   new_byte = byte_val;
      endcase
   end

   always_comb begin
      row_valid_in = row_valid_ff;
      if (wr_en) begin
         row_valid_in[tgt_row[AW-1:0]] = 1'b1;
      end
   end

   bmap_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (ROWS)
   ) u_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (tgt_row[AW-1:0]),
      .wdata (new_byte),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff        <= CSR_RESET;
         row_valid_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
         check_vld_ff  <= 1'b0;
         found_ff      <= 1'b0;
         scan_issue_ff <= '0;
      end else begin
         if (csr_we) csr_ff <= csr_wdata;
         row_valid_ff <= row_valid_in;

         if (ctl.load_result) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end

         if (ctl.update) begin
            scan_issue_ff <= '0;
            check_vld_ff  <= 1'b0;
            found_ff      <= 1'b0;
         end else begin
            check_vld_ff <= issue;
            if (issue) scan_issue_ff <= scan_issue_ff + 1'b1;
            if (ctl.scan_run && check_vld_ff && !found_ff && byte_val != '1) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= row_valid_ff[rd_addr];
      if (ctl.capture) begin
         cmd_ff <= req_command;
         bit_ff <= req_bit_index;
         oor_ff <= {1'b0, 5'(req_bit_index >> ROW_SHIFT)} >= rows_lim;
      end
      if (ctl.update) begin
         bit_value_ff <= oor_ff ? 1'b0 : new_byte[bit_ff[2:0]];
         first_ff     <= '0;
      end else if (ctl.scan_run && check_vld_ff && !found_ff && byte_val != '1) begin
         first_ff <= {check_row_ff, low_zero(byte_val)};
      end
      if (issue) check_row_ff <= 5'(scan_issue_ff);
      if (ctl.load_result) begin
         rsp_bit_value_ff    <= bit_value_ff;
         rsp_first_ff        <= first_ff;
         rsp_none_free_ff    <= !found_ff;
         rsp_out_of_range_ff <= oor_ff;
      end
   end

   assign sts.scan_done = found_ff || (!issue_ok && !check_vld_ff);
   assign sts.rsp_busy  = rsp_tvalid_ff && !rsp_tready;

   assign rsp_tvalid           = rsp_tvalid_ff;
   assign rsp_bit_value        = rsp_bit_value_ff;
   assign rsp_first_free_index = rsp_first_ff;
   assign rsp_none_free        = rsp_none_free_ff;
   assign rsp_out_of_range     = rsp_out_of_range_ff;

endmodule

// ----- rtl/bitmap_allocator_first_free.sv -----
// Top level of the allocation bitmap block with first-free search.
//
// Channels: req_ carries one command item (set, clear or test of one bit),
// rsp_ returns exactly one result item per command, in order. csr_we and
// csr_wdata write bytes_in_use, the number of 8-bit rows addressed and
// searched; write it only while the block is idle.
// Timing: an accepted item has its row read (ST_READ), then updated
// (ST_MODIFY); then the scan reads rows 0 upward, one per cycle from the
// single RAM read port, checks each row the cycle after its read and stops
// the cycle after the first row with a zero bit. rsp_tvalid rises in the
// same cycle in which the next item can be taken. Apart from a stalled
// result, the scan over the row RAM sets when the next item can be taken.
// Reset: the map reads as all zero (per-row valid bits cleared at once, no
// clearing pass), bytes_in_use returns to 32, no result is pending.
// Stall: a result waits in the output register while the next item is
// taken and worked on; that item then waits until the register is free.
module bitmap_allocator_first_free #(
   parameter int MAP_BYTES = bmap_pkg::MAP_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request: [1:0] command, [9:2] bit_index, [15:10] zero
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bmap_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // response: [0] bit_value, [8:1] first_free_index, [9] none_free,
   // [10] out_of_range, [15:11] zero
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bmap_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // bytes_in_use register
   input  logic                               csr_we,
   input  logic [bmap_pkg::CSR_W-1:0]         csr_wdata
);
   import bmap_pkg::*;

   ctl_type ctl;
   sts_type sts;

   logic       rsp_bit_value;
   logic [7:0] rsp_first_free_index;
   logic       rsp_none_free;
   logic       rsp_out_of_range;

   bmap_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   bmap_dp #(
      .MAP_BYTES (MAP_BYTES)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .ctl                  (ctl),
      .sts                  (sts),
      .req_command          (req_tdata[1:0]),
      .req_bit_index        (req_tdata[9:2]),
      .csr_we               (csr_we),
      .csr_wdata            (csr_wdata),
      .rsp_tvalid           (rsp_tvalid),
      .rsp_tready           (rsp_tready),
      .rsp_bit_value        (rsp_bit_value),
      .rsp_first_free_index (rsp_first_free_index),
      .rsp_none_free        (rsp_none_free),
      .rsp_out_of_range     (rsp_out_of_range)
   );

   // pack the result item, lowest field first
   assign rsp_tdata = {5'd0, rsp_out_of_range, rsp_none_free,
                       rsp_first_free_index, rsp_bit_value};

endmodule

// ----- rtl/bmap_checker.sv -----
// Port-level assertions of the allocation bitmap block, bound to its top.
module bmap_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [bmap_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [bmap_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import bmap_pkg::*;

   // one item at a time: ready drops right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready stayed high after an accepted item");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result item changed or vanished");

   // full map reports index zero
   a_none_free_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |-> rsp_tdata[8:1] == 8'd0)
      else $error("first_free_index nonzero with none_free set");

   // out-of-range bit reads as zero
   a_oor_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> !rsp_tdata[0])
      else $error("bit_value set on an out-of-range item");

endmodule

bind bitmap_allocator_first_free bmap_checker u_bmap_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
